// ----- design/snrt_pkg.sv -----
// ---------------------------------------------------------------------------
// snrt_pkg
// Shared widths, register indexes, reset values and types of the sector
// nearest-range tracker.
// ---------------------------------------------------------------------------
package snrt_pkg;

   localparam int RANGE_W    = 16;
   localparam int ANGLE_W    = 23;
   localparam int STEP_W     = 16;
   localparam int BOUND_W    = 17;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 23;
   localparam int NUM_SECTOR = 3;

   localparam int SECTOR_RIGHT  = 0;
   localparam int SECTOR_MIDDLE = 1;
   localparam int SECTOR_LEFT   = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ANGLE_START        = 3'd0,
      CSR_ANGLE_STEP         = 3'd1,
      CSR_RANGE_LIMIT        = 3'd2,
      CSR_RIGHT_UPPER_BOUND  = 3'd3,
      CSR_RIGHT_LOWER_BOUND  = 3'd4,
      CSR_MIDDLE_LOWER_BOUND = 3'd5,
      CSR_LEFT_LOWER_BOUND   = 3'd6
   } csr_index_type;

   localparam logic [ANGLE_W-1:0] RST_ANGLE_START        = 23'd0;
   localparam logic [STEP_W-1:0]  RST_ANGLE_STEP         = 16'd256;
   localparam logic [RANGE_W-1:0] RST_RANGE_LIMIT        = 16'd1024;
   localparam logic [BOUND_W-1:0] RST_RIGHT_UPPER_BOUND  = 17'd69120;
   localparam logic [BOUND_W-1:0] RST_RIGHT_LOWER_BOUND  = 17'd49920;
   localparam logic [BOUND_W-1:0] RST_MIDDLE_LOWER_BOUND = 17'd42240;
   localparam logic [BOUND_W-1:0] RST_LEFT_LOWER_BOUND   = 17'd23040;

   typedef struct packed {
      logic [BOUND_W-1:0] right_upper;
      logic [BOUND_W-1:0] right_lower;
      logic [BOUND_W-1:0] middle_lower;
      logic [BOUND_W-1:0] left_lower;
   } bounds_type;

   // bit positions follow the SECTOR_* indexes
   typedef struct packed {
      logic left;
      logic middle;
      logic right;
   } sector_sel_type;

endpackage

// ----- design/snrt_ifs.sv -----
// ---------------------------------------------------------------------------
// snrt_ifs
// Valid/ready channels of the tracker: sample input, result output and
// register write port.
// ---------------------------------------------------------------------------
interface snrt_req_if import snrt_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [RANGE_W-1:0] range_sample;
   logic               scan_start;
   logic               scan_end;

   modport source (output valid, output range_sample, output scan_start,
                   output scan_end, input ready);
   modport sink   (input valid, input range_sample, input scan_start,
                   input scan_end, output ready);
endinterface

interface snrt_rsp_if import snrt_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [RANGE_W-1:0]        right_nearest;
   logic signed [ANGLE_W-1:0] right_nearest_angle;
   logic [RANGE_W-1:0]        middle_nearest;
   logic signed [ANGLE_W-1:0] middle_nearest_angle;
   logic [RANGE_W-1:0]        left_nearest;
   logic signed [ANGLE_W-1:0] left_nearest_angle;

   modport source (output valid, output right_nearest, output right_nearest_angle,
                   output middle_nearest, output middle_nearest_angle,
                   output left_nearest, output left_nearest_angle, input ready);
   modport sink   (input valid, input right_nearest, input right_nearest_angle,
                   input middle_nearest, input middle_nearest_angle,
                   input left_nearest, input left_nearest_angle, output ready);
endinterface

interface snrt_csr_if import snrt_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/sector_nearest_range_tracker.sv -----
// ---------------------------------------------------------------------------
// sector_nearest_range_tracker
// Pipeline: input register, then the sector compare and minimum update into
// the result register.
// Throughput: 1 item per cycle; a waiting result only stalls scan-end items.
// Reset: synchronous; registers return to defaults, minima to all ones.
// ---------------------------------------------------------------------------
module sector_nearest_range_tracker import snrt_pkg::*; #(
   parameter int RANGE_BITS = 16,
   parameter int ANGLE_BITS = 24
) (
   input  logic       clock,
   input  logic       reset,
   snrt_req_if.sink   req_chan,
   snrt_rsp_if.source rsp_chan,
   snrt_csr_if.sink   csr_chan
);

   localparam int RCMP_W  = (RANGE_BITS > RANGE_W) ? RANGE_BITS : RANGE_W;
   localparam int AEXT_W  = (ANGLE_BITS > ANGLE_W) ? ANGLE_BITS : ANGLE_W;

   // configuration
   logic [ANGLE_W-1:0] cfg_angle_start_ff;
   logic [STEP_W-1:0]  cfg_angle_step_ff;
   logic [RANGE_W-1:0] cfg_range_limit_ff;
   bounds_type         cfg_bounds_ff;

   // input register
   logic               s1_valid_ff;
   logic [RANGE_W-1:0] s1_range_ff;
   logic               s1_start_ff;
   logic               s1_end_ff;

   // scan state
   logic [ANGLE_BITS-1:0] cur_angle_ff;
   logic [ANGLE_BITS-1:0] cur_angle_in;
   logic [RANGE_BITS-1:0] min_range_ff [NUM_SECTOR];
   logic [RANGE_BITS-1:0] min_range_in [NUM_SECTOR];
   logic [ANGLE_BITS-1:0] min_angle_ff [NUM_SECTOR];
   logic [ANGLE_BITS-1:0] min_angle_in [NUM_SECTOR];

   // result register
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic [RANGE_W-1:0]        rsp_range_ff [NUM_SECTOR];
   logic [RANGE_W-1:0]        rsp_range_in [NUM_SECTOR];
   logic signed [ANGLE_W-1:0] rsp_angle_ff [NUM_SECTOR];
   logic signed [ANGLE_W-1:0] rsp_angle_in [NUM_SECTOR];

   logic                     out_free;
   logic                     s1_fire;
   logic signed [AEXT_W-1:0] start_ext;
   logic [ANGLE_BITS-1:0]    step_ext;
   logic [ANGLE_BITS-1:0]    ang;
   logic                     hit;
   sector_sel_type           sel;
   logic [NUM_SECTOR-1:0]    sel_vec;
   logic [RCMP_W-1:0]        r_ext;
   logic [RANGE_BITS-1:0]    r_store;
   logic [RANGE_BITS-1:0]    base_range [NUM_SECTOR];
   logic [RCMP_W-1:0]        base_ext   [NUM_SECTOR];
   logic [RCMP_W-1:0]        next_ext   [NUM_SECTOR];
   logic signed [AEXT_W-1:0] next_ang_ext [NUM_SECTOR];

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign s1_fire        = s1_valid_ff && (!s1_end_ff || out_free);
   assign req_chan.ready = !s1_valid_ff || s1_fire;
   assign csr_chan.ready = 1'b1;

   assign start_ext = AEXT_W'($signed(cfg_angle_start_ff));
   assign step_ext  = ANGLE_BITS'($signed(cfg_angle_step_ff));
   assign ang       = s1_start_ff ? start_ext[ANGLE_BITS-1:0] : cur_angle_ff;
   assign hit       = (s1_range_ff != '0) && (s1_range_ff < cfg_range_limit_ff);
   assign r_ext     = RCMP_W'(s1_range_ff);
   assign r_store   = r_ext[RANGE_BITS-1:0];
   assign sel_vec   = sel;

   assign cur_angle_in = ang + step_ext;

   snrt_sector #(
      .ANGLE_BITS(ANGLE_BITS)
   ) u_sector (
      .angle  (ang),
      .bounds (cfg_bounds_ff),
      .sel    (sel)
   );

   always_comb begin
      for (int i = 0; i < NUM_SECTOR; i++) begin
         base_range[i] = s1_start_ff ? '1 : min_range_ff[i];
         base_ext[i]   = RCMP_W'(base_range[i]);
         if (hit && sel_vec[i] && (r_ext < base_ext[i])) begin
            min_range_in[i] = r_store;
            min_angle_in[i] = ang;
         end else begin
            min_range_in[i] = base_range[i];
            min_angle_in[i] = min_angle_ff[i];
         end
         next_ext[i]     = RCMP_W'(min_range_in[i]);
         next_ang_ext[i] = AEXT_W'($signed(min_angle_in[i]));
         rsp_range_in[i] = next_ext[i][RANGE_W-1:0];
         rsp_angle_in[i] = next_ang_ext[i][ANGLE_W-1:0];
      end
   end

   assign rsp_valid_in = (s1_fire && s1_end_ff) || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_angle_start_ff         <= RST_ANGLE_START;
         cfg_angle_step_ff          <= RST_ANGLE_STEP;
         cfg_range_limit_ff         <= RST_RANGE_LIMIT;
         cfg_bounds_ff.right_upper  <= RST_RIGHT_UPPER_BOUND;
         cfg_bounds_ff.right_lower  <= RST_RIGHT_LOWER_BOUND;
         cfg_bounds_ff.middle_lower <= RST_MIDDLE_LOWER_BOUND;
         cfg_bounds_ff.left_lower   <= RST_LEFT_LOWER_BOUND;
      end else if (csr_chan.valid) begin
         unique case (csr_index_type'(csr_chan.index))
            CSR_ANGLE_START: begin
               cfg_angle_start_ff <= csr_chan.data[ANGLE_W-1:0];
            end
            CSR_ANGLE_STEP: begin
               cfg_angle_step_ff <= csr_chan.data[STEP_W-1:0];
            end
            CSR_RANGE_LIMIT: begin
               cfg_range_limit_ff <= csr_chan.data[RANGE_W-1:0];
            end
            CSR_RIGHT_UPPER_BOUND: begin
               cfg_bounds_ff.right_upper <= csr_chan.data[BOUND_W-1:0];
            end
            CSR_RIGHT_LOWER_BOUND: begin
               cfg_bounds_ff.right_lower <= csr_chan.data[BOUND_W-1:0];
            end
            CSR_MIDDLE_LOWER_BOUND: begin
               cfg_bounds_ff.middle_lower <= csr_chan.data[BOUND_W-1:0];
            end
            CSR_LEFT_LOWER_BOUND: begin
               cfg_bounds_ff.left_lower <= csr_chan.data[BOUND_W-1:0];
            end
            default: begin
               cfg_angle_start_ff <= cfg_angle_start_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cur_angle_ff <= '0;
         for (int i = 0; i < NUM_SECTOR; i++) begin
            min_range_ff[i] <= '1;
            min_angle_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_chan.ready) begin
            s1_valid_ff <= req_chan.valid;
         end
         if (s1_fire) begin
            cur_angle_ff <= cur_angle_in;
            for (int i = 0; i < NUM_SECTOR; i++) begin
               min_range_ff[i] <= min_range_in[i];
               min_angle_ff[i] <= min_angle_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         s1_range_ff <= req_chan.range_sample;
         s1_start_ff <= req_chan.scan_start;
         s1_end_ff   <= req_chan.scan_end;
      end
      if (s1_fire && s1_end_ff) begin
         for (int i = 0; i < NUM_SECTOR; i++) begin
            rsp_range_ff[i] <= rsp_range_in[i];
            rsp_angle_ff[i] <= rsp_angle_in[i];
         end
      end
   end

   assign rsp_chan.valid                = rsp_valid_ff;
   assign rsp_chan.right_nearest        = rsp_range_ff[SECTOR_RIGHT];
   assign rsp_chan.right_nearest_angle  = rsp_angle_ff[SECTOR_RIGHT];
   assign rsp_chan.middle_nearest       = rsp_range_ff[SECTOR_MIDDLE];
   assign rsp_chan.middle_nearest_angle = rsp_angle_ff[SECTOR_MIDDLE];
   assign rsp_chan.left_nearest         = rsp_range_ff[SECTOR_LEFT];
   assign rsp_chan.left_nearest_angle   = rsp_angle_ff[SECTOR_LEFT];

endmodule

// ----- design/snrt_sector.sv -----
// ---------------------------------------------------------------------------
// snrt_sector
// Sorts a signed angle into the right, middle or left sector. Right is tested
// first, then middle, then left, so shared bounds go to the earlier sector.
// ---------------------------------------------------------------------------
module snrt_sector import snrt_pkg::*; #(
   parameter int ANGLE_BITS = 24
) (
   input  logic [ANGLE_BITS-1:0] angle,
   input  bounds_type            bounds,
   output sector_sel_type        sel
);

   localparam int CMP_W = (ANGLE_BITS > BOUND_W + 1) ? ANGLE_BITS : BOUND_W + 1;

   logic signed [CMP_W-1:0] a_cmp;
   logic signed [CMP_W-1:0] ru_cmp;
   logic signed [CMP_W-1:0] rl_cmp;
   logic signed [CMP_W-1:0] ml_cmp;
   logic signed [CMP_W-1:0] ll_cmp;
   logic                    in_right;
   logic                    in_middle;
   logic                    in_left;

   assign a_cmp  = CMP_W'($signed(angle));
   assign ru_cmp = $signed({{(CMP_W-BOUND_W){1'b0}}, bounds.right_upper});
   assign rl_cmp = $signed({{(CMP_W-BOUND_W){1'b0}}, bounds.right_lower});
   assign ml_cmp = $signed({{(CMP_W-BOUND_W){1'b0}}, bounds.middle_lower});
   assign ll_cmp = $signed({{(CMP_W-BOUND_W){1'b0}}, bounds.left_lower});

   assign in_right  = (a_cmp >= rl_cmp) && (a_cmp <= ru_cmp);
   assign in_middle = (a_cmp >= ml_cmp) && (a_cmp <= rl_cmp);
   assign in_left   = (a_cmp >= ll_cmp) && (a_cmp <= ml_cmp);

   always_comb begin
      sel = '0;
      priority if (in_right) begin
         sel.right = 1'b1;
      end else if (in_middle) begin
         sel.middle = 1'b1;
      end else if (in_left) begin
         sel.left = 1'b1;
      end else begin
         sel = '0;
      end
   end

endmodule

// ----- design/snrt_checker.sv -----
// ---------------------------------------------------------------------------
// snrt_checker
// Port-level checks of the tracker, bound to the top level.
// ---------------------------------------------------------------------------
module snrt_checker import snrt_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [RANGE_W-1:0]        right_nearest,
   input logic signed [ANGLE_W-1:0] right_nearest_angle,
   input logic [RANGE_W-1:0]        middle_nearest,
   input logic signed [ANGLE_W-1:0] middle_nearest_angle,
   input logic [RANGE_W-1:0]        left_nearest,
   input logic signed [ANGLE_W-1:0] left_nearest_angle
);

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(right_nearest)
         && $stable(right_nearest_angle) && $stable(middle_nearest)
         && $stable(middle_nearest_angle) && $stable(left_nearest)
         && $stable(left_nearest_angle))
      else $error("snrt: stalled item changed");

   // reset leaves no result pending
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("snrt: result valid after reset");

   // an empty output register never blocks input
   assert property (@(posedge clock) disable iff (reset) !rsp_valid |-> req_ready)
      else $error("snrt: input stalled with output free");

   // zero ranges are dropped, so no minimum is zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (right_nearest != '0) && (middle_nearest != '0)
         && (left_nearest != '0))
      else $error("snrt: zero range reported");

endmodule

bind sector_nearest_range_tracker snrt_checker u_snrt_checker (
   .clock                (clock),
   .reset                (reset),
   .req_ready            (req_chan.ready),
   .rsp_valid            (rsp_chan.valid),
   .rsp_ready            (rsp_chan.ready),
   .right_nearest        (rsp_chan.right_nearest),
   .right_nearest_angle  (rsp_chan.right_nearest_angle),
   .middle_nearest       (rsp_chan.middle_nearest),
   .middle_nearest_angle (rsp_chan.middle_nearest_angle),
   .left_nearest         (rsp_chan.left_nearest),
   .left_nearest_angle   (rsp_chan.left_nearest_angle)
);

// ----- sim/sector_nearest_range_tracker_tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// sector_nearest_range_tracker_tb
// Streams lidar range samples through the tracker under several register
// settings and checks every scan report against a cycle-free model of the
// sector minimum search, with random sender gaps and receiver stalls.
// ---------------------------------------------------------------------------
module sector_nearest_range_tracker_tb import snrt_pkg::*; ();

   localparam int TRACK_W = 24;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_INDEX = 3'd7;

   typedef struct packed {
      logic [RANGE_W-1:0] range_sample;
      logic               scan_start;
      logic               scan_end;
   } lidar_sample_type;

   typedef struct packed {
      logic [NUM_SECTOR-1:0][RANGE_W-1:0] nearest;
      logic [NUM_SECTOR-1:0][ANGLE_W-1:0] angle;
   } sector_report_type;

   logic clock = 1'b0;
   logic reset;

   snrt_req_if req_bus ();
   snrt_rsp_if rsp_bus ();
   snrt_csr_if csr_bus ();

   sector_nearest_range_tracker dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always #1 clock = ~clock;

   // register shadow
   logic [ANGLE_W-1:0] cfg_angle_start;
   logic [STEP_W-1:0]  cfg_angle_step;
   logic [RANGE_W-1:0] cfg_range_limit;
   logic [BOUND_W-1:0] cfg_right_upper;
   logic [BOUND_W-1:0] cfg_right_lower;
   logic [BOUND_W-1:0] cfg_middle_lower;
   logic [BOUND_W-1:0] cfg_left_lower;

   // tracker state
   logic [TRACK_W-1:0] track_angle;
   logic [RANGE_W-1:0] min_range [NUM_SECTOR];
   logic [TRACK_W-1:0] min_angle [NUM_SECTOR];

   lidar_sample_type  sample_backlog [$];
   sector_report_type expected_reports [$];
   string             side [NUM_SECTOR] = '{"right", "middle", "left"};

   int                mismatch_count = 0;
   logic              req_taken = 1'b0;
   lidar_sample_type  seen_sample;
   lidar_sample_type  drive_sample;
   sector_report_type want_report;
   sector_report_type got_report;
   int                burst_left = 1;
   int                gap_left = 0;
   int                stall_mode = 0;
   int                mode_left = 0;
   int                stall_phase = 0;

   function automatic void track_sample(lidar_sample_type s);
      logic [TRACK_W-1:0] ang;
      int a;
      int hit;
      int k;
      int ru, rl, ml, ll;
      sector_report_type rep;
      ru = cfg_right_upper;
      rl = cfg_right_lower;
      ml = cfg_middle_lower;
      ll = cfg_left_lower;
      if (s.scan_start) begin
         for (k = 0; k < NUM_SECTOR; k++) min_range[k] = '1;
         ang = {cfg_angle_start[ANGLE_W-1], cfg_angle_start};
      end else begin
         ang = track_angle;
      end
      a = $signed(ang);
      hit = -1;
      if (s.range_sample != 0 && s.range_sample < cfg_range_limit) begin
         if (a >= rl && a <= ru) hit = SECTOR_RIGHT;
         else if (a >= ml && a <= rl) hit = SECTOR_MIDDLE;
         else if (a >= ll && a <= ml) hit = SECTOR_LEFT;
      end
      if (hit >= 0 && s.range_sample < min_range[hit]) begin
         min_range[hit] = s.range_sample;
         min_angle[hit] = ang;
      end
      track_angle = ang + {{(TRACK_W-STEP_W){cfg_angle_step[STEP_W-1]}}, cfg_angle_step};
      if (s.scan_end) begin
         for (k = 0; k < NUM_SECTOR; k++) begin
            rep.nearest[k] = min_range[k];
            rep.angle[k]   = min_angle[k][ANGLE_W-1:0];
         end
         expected_reports.push_back(rep);
      end
   endfunction

   function automatic logic [RANGE_W-1:0] pick_range();
      int lim;
      lim = cfg_range_limit;
      case ($urandom_range(0, 7))
         0: return '0;
         1: return RANGE_W'(lim + $urandom_range(0, 65535 - lim));
         2, 3: begin
            if (lim <= 1) return RANGE_W'($urandom_range(0, 65535));
            return RANGE_W'($urandom_range(1, (lim - 1 < 20) ? lim - 1 : 20));
         end
         default: begin
            if (lim <= 1) return RANGE_W'($urandom_range(0, 65535));
            return RANGE_W'($urandom_range(1, lim - 1));
         end
      endcase
   endfunction

   task automatic push_sample(logic [RANGE_W-1:0] r, logic s, logic e);
      lidar_sample_type item;
      item.range_sample = r;
      item.scan_start   = s;
      item.scan_end     = e;
      sample_backlog.push_back(item);
   endtask

   // mostly well-formed scans, some with stray start/end marks
   task automatic queue_scans(int count);
      int len;
      int i;
      int queued;
      bit noisy;
      queued = 0;
      while (queued < count) begin
         len = $urandom_range(1, 16);
         noisy = ($urandom_range(0, 5) == 0);
         for (i = 0; i < len; i++) begin
            if (noisy)
               push_sample(pick_range(), $urandom_range(0, 4) == 0,
                           $urandom_range(0, 4) == 0);
            else
               push_sample(pick_range(), i == 0, i == len - 1);
         end
         queued += len;
      end
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int value);
      int w;
      int mask;
      logic [CSR_DATA_W-1:0] word;
      case (idx)
         CSR_ANGLE_START: w = ANGLE_W;
         CSR_ANGLE_STEP:  w = STEP_W;
         CSR_RANGE_LIMIT: w = RANGE_W;
         default:         w = BOUND_W;
      endcase
      mask = (1 << w) - 1;
      if (w < CSR_DATA_W && $urandom_range(0, 1))
         word = CSR_DATA_W'((value & mask) | ($urandom & ~mask));
      else
         word = CSR_DATA_W'(value & mask);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= word;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic set_sweep(int start_ang, int step_ang, int lim,
                            int ru, int rl, int ml, int ll);
      write_reg(CSR_ANGLE_START, start_ang);
      write_reg(CSR_ANGLE_STEP, step_ang);
      write_reg(CSR_RANGE_LIMIT, lim);
      write_reg(CSR_RIGHT_UPPER_BOUND, ru);
      write_reg(CSR_RIGHT_LOWER_BOUND, rl);
      write_reg(CSR_MIDDLE_LOWER_BOUND, ml);
      write_reg(CSR_LEFT_LOWER_BOUND, ll);
   endtask

   task automatic wait_idle();
      while (sample_backlog.size() != 0 || req_bus.valid || expected_reports.size() != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // sample driver: bursts with random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (req_bus.valid && !req_taken) begin
         req_bus.valid <= 1'b1;
      end else if (gap_left > 0) begin
         req_bus.valid <= 1'b0;
         gap_left--;
      end else if (sample_backlog.size() > 0) begin
         drive_sample = sample_backlog.pop_front();
         req_bus.valid        <= 1'b1;
         req_bus.range_sample <= drive_sample.range_sample;
         req_bus.scan_start   <= drive_sample.scan_start;
         req_bus.scan_end     <= drive_sample.scan_end;
         if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         end else begin
            burst_left--;
         end
      end else begin
         req_bus.valid <= 1'b0;
      end
   end

   // result receiver stall pattern
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(32, 200);
         end else begin
            mode_left--;
         end
         stall_phase++;
         case (stall_mode)
            0:       rsp_bus.ready <= 1'b1;
            1:       rsp_bus.ready <= ($urandom_range(0, 3) != 0);
            default: rsp_bus.ready <= ((stall_phase % 9) < 3);
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_taken        = 1'b0;
         cfg_angle_start  = RST_ANGLE_START;
         cfg_angle_step   = RST_ANGLE_STEP;
         cfg_range_limit  = RST_RANGE_LIMIT;
         cfg_right_upper  = RST_RIGHT_UPPER_BOUND;
         cfg_right_lower  = RST_RIGHT_LOWER_BOUND;
         cfg_middle_lower = RST_MIDDLE_LOWER_BOUND;
         cfg_left_lower   = RST_LEFT_LOWER_BOUND;
         track_angle      = '0;
         for (int k = 0; k < NUM_SECTOR; k++) begin
            min_range[k] = '1;
            min_angle[k] = '0;
         end
      end else begin
         req_taken = req_bus.valid && req_bus.ready;
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               CSR_ANGLE_START:        cfg_angle_start  = csr_bus.data[ANGLE_W-1:0];
               CSR_ANGLE_STEP:         cfg_angle_step   = csr_bus.data[STEP_W-1:0];
               CSR_RANGE_LIMIT:        cfg_range_limit  = csr_bus.data[RANGE_W-1:0];
               CSR_RIGHT_UPPER_BOUND:  cfg_right_upper  = csr_bus.data[BOUND_W-1:0];
               CSR_RIGHT_LOWER_BOUND:  cfg_right_lower  = csr_bus.data[BOUND_W-1:0];
               CSR_MIDDLE_LOWER_BOUND: cfg_middle_lower = csr_bus.data[BOUND_W-1:0];
               CSR_LEFT_LOWER_BOUND:   cfg_left_lower   = csr_bus.data[BOUND_W-1:0];
               default: ;
            endcase
         end
         if (req_taken) begin
            seen_sample.range_sample = req_bus.range_sample;
            seen_sample.scan_start   = req_bus.scan_start;
            seen_sample.scan_end     = req_bus.scan_end;
            track_sample(seen_sample);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got_report.nearest[SECTOR_RIGHT]  = rsp_bus.right_nearest;
            got_report.angle[SECTOR_RIGHT]    = rsp_bus.right_nearest_angle;
            got_report.nearest[SECTOR_MIDDLE] = rsp_bus.middle_nearest;
            got_report.angle[SECTOR_MIDDLE]   = rsp_bus.middle_nearest_angle;
            got_report.nearest[SECTOR_LEFT]   = rsp_bus.left_nearest;
            got_report.angle[SECTOR_LEFT]     = rsp_bus.left_nearest_angle;
            if (expected_reports.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected scan report, expected none, got right %0d",
                        $time, got_report.nearest[SECTOR_RIGHT]);
            end else begin
               want_report = expected_reports.pop_front();
               for (int k = 0; k < NUM_SECTOR; k++) begin
                  if (got_report.nearest[k] !== want_report.nearest[k]) begin
                     mismatch_count++;
                     $display("%0t: %s nearest expected %0d, got %0d", $time, side[k],
                              want_report.nearest[k], got_report.nearest[k]);
                  end
                  if (got_report.angle[k] !== want_report.angle[k]) begin
                     mismatch_count++;
                     $display("%0t: %s nearest angle expected %0d, got %0d", $time,
                              side[k], $signed(want_report.angle[k]),
                              $signed(got_report.angle[k]));
                  end
               end
            end
         end
      end
   end

   initial begin
      int b [$];
      int mag;
      int start_ang;
      int step_ang;
      int lim;
      int p;
      int i;
      reset = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.range_sample = '0;
      req_bus.scan_start   = 1'b0;
      req_bus.scan_end     = 1'b0;
      rsp_bus.ready        = 1'b0;
      csr_bus.valid        = 1'b0;
      csr_bus.index        = '0;
      csr_bus.data         = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset values: nothing in any sector
      push_sample(16'd500, 1'b1, 1'b0);
      push_sample(16'd0, 1'b0, 1'b0);
      push_sample(16'hFFFF, 1'b0, 1'b1);
      push_sample(16'd7, 1'b1, 1'b1);
      wait_idle();

      // sweep in 15 degree steps landing on every sector bound
      set_sweep(19200, 3840, 1024, 69120, 49920, 42240, 23040);
      push_sample(16'd100, 1'b1, 1'b0);
      push_sample(16'd50, 1'b0, 1'b0);    // left lower bound
      push_sample(16'd60, 1'b0, 1'b0);
      push_sample(16'd0, 1'b0, 1'b0);
      push_sample(16'd1024, 1'b0, 1'b0);  // at limit
      push_sample(16'hFFFF, 1'b0, 1'b0);
      push_sample(16'd40, 1'b0, 1'b0);    // middle/left bound -> middle
      push_sample(16'd40, 1'b0, 1'b0);    // equal, no replace
      push_sample(16'd30, 1'b0, 1'b0);    // right/middle bound -> right
      push_sample(16'd1, 1'b0, 1'b0);
      push_sample(16'd1023, 1'b0, 1'b0);
      push_sample(16'd1, 1'b0, 1'b0);
      push_sample(16'd5, 1'b0, 1'b0);
      push_sample(16'd2, 1'b0, 1'b0);     // right upper bound
      push_sample(16'd3, 1'b0, 1'b1);
      push_sample(16'd9, 1'b0, 1'b0);     // minima carry past scan end
      push_sample(16'd8, 1'b0, 1'b1);
      push_sample(16'd4, 1'b1, 1'b1);     // single-sample scan, kept angles
      wait_idle();

      // zero limit drops everything
      set_sweep(-4194304, 32767, 0, 92160, 61440, 30720, 0);
      write_reg(CSR_SPARE_INDEX, $urandom);
      queue_scans(60);
      wait_idle();

      // angle wraps past the positive end
      set_sweep(4194303, 32767, 65535, 92160, 61440, 30720, 0);
      push_sample(pick_range(), 1'b1, 1'b0);
      for (i = 1; i < 140; i++) push_sample(pick_range(), 1'b0, (i % 10) == 9);
      wait_idle();

      set_sweep(92160, -32768, 65535, 92160, 92160, 26624, 0);
      queue_scans(60);
      wait_idle();

      for (p = 0; p < 5; p++) begin
         b.delete();
         for (i = 0; i < 4; i++) b.push_back($urandom_range(0, 92160));
         if ($urandom_range(0, 3) != 0) begin
            b.sort();
            if ($urandom_range(0, 3) == 0) b[1] = b[2];
         end
         mag = $urandom_range(500, 12000);
         if ($urandom_range(0, 1)) begin
            step_ang = mag;
            start_ang = b[0] - $urandom_range(0, 2 * mag);
         end else begin
            step_ang = -mag;
            start_ang = b[3] + $urandom_range(0, 2 * mag);
         end
         case ($urandom_range(0, 3))
            0:       lim = 65535;
            1:       lim = $urandom_range(2, 300);
            default: lim = $urandom_range(1, 65535);
         endcase
         set_sweep(start_ang, step_ang, lim, b[3], b[2], b[1], b[0]);
         queue_scans(50);
         if (p == 2) wait_idle();
         queue_scans(50);
         wait_idle();
      end

      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
